### rtl/core/pcmf_pkg.sv
// Package for the PCM to float32 sample converter.
// Holds register indexes, field widths and the gathered-sample struct; no dependencies.
package pcmf_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_BYTES_PER_SAMPLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FRAME_COUNT      = 2'd2;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  width;
    logic [2:0]  channel;
    logic        last;
  } sample_t;
endpackage

### rtl/core/pcmf_gather.sv
// Byte gatherer: assembles little-endian bytes into samples and tracks channel and frame.
// Depends on pcmf_pkg.
module pcmf_gather #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic [2:0]       bytes_per_sample,
  input  logic [3:0]       channel_count,
  input  logic [31:0]      frame_count,
  output logic             done,
  output pcmf_pkg::sample_t smp
);
  import pcmf_pkg::*;

  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [23:0]    partial_r, partial_nxt;
  logic [1:0]     pos_r, pos_nxt;
  logic [ChW-1:0] chan_r, chan_nxt;
  logic [31:0]    frames_r, frames_nxt;
  logic [2:0]     width;
  logic [6:0]     chans;
  logic [31:0]    word;
  logic           frame_end;

  always_comb begin
    width = bytes_per_sample;
    if (width == 3'd0) width = 3'd1;
    if (width > 3'd4) width = 3'd4;
    chans = {3'd0, channel_count};
    if (chans == 7'd0) chans = 7'd1;
    if (chans > 7'(MAX_CHANNELS)) chans = 7'(MAX_CHANNELS);
    word = {8'd0, partial_r} | ({24'd0, data_byte} << {pos_r, 3'd0});
    done = ({1'b0, pos_r} + 3'd1) >= width;
    frame_end = (7'(chan_r) + 7'd1) >= chans;
    partial_nxt = partial_r;
    pos_nxt = pos_r;
    chan_nxt = chan_r;
    frames_nxt = frames_r;
    if (step) begin
      if (!done) begin
        partial_nxt = word[23:0];
        pos_nxt = pos_r + 2'd1;
      end else begin
        partial_nxt = '0;
        pos_nxt = '0;
        if (frame_end) begin
          chan_nxt = '0;
          frames_nxt = frames_r + 32'd1;
        end else begin
          chan_nxt = chan_r + ChW'(1);
        end
      end
    end
    smp.word = word;
    smp.width = width;
    smp.channel = 3'(chan_r);
    smp.last = frame_end && (frame_count != 32'd0) && (frames_r == frame_count - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pos_r <= '0;
      chan_r <= '0;
      frames_r <= '0;
    end else begin
      partial_r <= partial_nxt;
      pos_r <= pos_nxt;
      chan_r <= chan_nxt;
      frames_r <= frames_nxt;
    end
  end
endmodule

### rtl/core/pcmf_convert.sv
// Integer to float32 converter with round to nearest even.
// Depends on pcmf_pkg.
module pcmf_convert (
  input  pcmf_pkg::sample_t smp,
  output logic [31:0]       fbits
);
  import pcmf_pkg::*;

  logic [31:0] val, mag, norm;
  logic [4:0]  p;
  logic [7:0]  expo;
  logic [24:0] mant;
  logic        guard, sticky;

  always_comb begin
    case (smp.width)
      3'd1:    val = {24'd0, smp.word[7:0]} - 32'd128;
      3'd2:    val = {{16{smp.word[15]}}, smp.word[15:0]};
      3'd3:    val = {{8{smp.word[23]}}, smp.word[23:0]};
      default: val = smp.word;
    endcase
    mag = val[31] ? (32'd0 - val) : val;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd31 - p);
    guard = norm[7];
    sticky = |norm[6:0];
    mant = {1'b0, norm[31:8]};
    if (guard && (sticky || norm[8])) mant = mant + 25'd1;
    expo = 8'd127 + {3'd0, p};
    if (mant[24]) begin
      expo = expo + 8'd1;
      mant = mant >> 1;
    end
    if (mag == 32'd0) fbits = '0;
    else fbits = {val[31], expo, mant[22:0]};
  end
endmodule

### rtl/core/pcm_to_float_sample_converter_core.sv
// Top level of the PCM to float32 sample converter: config registers, gatherer, output stage.
// Depends on pcmf_pkg, pcmf_gather and pcmf_convert.
//
//   Channel | Dir | tdata / payload
//   in_     | in  | data_byte[7:0]
//   out_    | out | sample_float[31:0], channel_index[34:32]; tlast = last_sample
//   cfg_    | in  | index 0..2, data[31:0]
//
// A byte is taken per cycle if not stalled; a sample appears the cycle after its last byte.
// The output register parts the two sides: a new byte is taken while the result
// register is empty or being emptied. Reset is synchronous and restores defaults.
module pcm_to_float_sample_converter_core #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] sample_float, [34:32] channel_index, rest zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pcmf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import pcmf_pkg::*;

  logic [2:0]  bps_r;
  logic [3:0]  chc_r;
  logic [31:0] frc_r;
  logic        step, done;
  sample_t     smp;
  logic [31:0] fbits;
  logic        ovalid_r;
  logic [31:0] ofloat_r;
  logic [2:0]  ochan_r;
  logic        olast_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !ovalid_r || out_tready;
  assign step = in_tvalid && in_tready;

  pcmf_gather #(.MAX_CHANNELS(MAX_CHANNELS)) u_gather (
    .clk, .rst_n, .step, .data_byte(in_tdata),
    .bytes_per_sample(bps_r), .channel_count(chc_r), .frame_count(frc_r),
    .done, .smp
  );

  pcmf_convert u_convert (.smp, .fbits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= 3'd2;
      chc_r <= 4'd2;
      frc_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_BYTES_PER_SAMPLE: bps_r <= cfg_data[2:0];
          REG_CHANNEL_COUNT:    chc_r <= cfg_data[3:0];
          REG_FRAME_COUNT:      frc_r <= cfg_data;
          default: ;
        endcase
      end
      if (step && done) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
    if (step && done) begin
      ofloat_r <= fbits;
      ochan_r <= smp.channel;
      olast_r <= smp.last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {5'd0, ochan_r, ofloat_r};
  assign out_tlast = olast_r;
endmodule

### rtl/core/pcmf_checker.sv
// Port-level checker for the PCM to float32 converter, bound to the top level.
// Depends on pcm_to_float_sample_converter_core.
module pcmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked with free output");
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:35] == 5'd0)
    else $error("padding bits not zero");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(in_tvalid && in_tready))
    else $error("result without an input item");
endmodule

bind pcm_to_float_sample_converter_core pcmf_checker u_pcmf_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

### dv/tb.sv
// Self-checking testbench for pcm_to_float_sample_converter_core.
// Drives PCM bytes and register writes, predicts float32 samples; depends on pcmf_pkg.
module tb;
  import pcmf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic [31:0] fbits;
    logic [2:0]  chan;
    logic        last;
  } sample_exp_t;

  sample_exp_t expected_samples[$];
  int mismatches = 0;
  bit stall_en = 1'b1;

  logic [2:0]  width_reg;
  logic [3:0]  chans_reg;
  logic [31:0] frames_reg;
  logic [23:0] gathered;
  logic [1:0]  byte_pos;
  logic [2:0]  cur_chan;
  logic [31:0] frames_done;

  pcm_to_float_sample_converter_core DUT (.*);

  always #4 clk = ~clk;

  function automatic logic [31:0] int_to_float(logic [31:0] v);
    logic [31:0] mag, mant, rem, half;
    logic [7:0]  expo;
    int p, sh;
    if (v == 0) return 32'd0;
    mag = v[31] ? -v : v;
    p = 31;
    while (!mag[p]) p--;
    expo = 8'(127 + p);
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant >= 32'h0100_0000) begin
        mant >>= 1;
        expo++;
      end
    end
    return {v[31], expo, mant[22:0]};
  endfunction

  task automatic predict_byte(logic [7:0] b);
    int w, nc;
    logic [31:0] word, val;
    logic fend;
    w = (width_reg < 1) ? 1 : (width_reg > 4) ? 4 : width_reg;
    nc = (chans_reg < 1) ? 1 : (chans_reg > 8) ? 8 : chans_reg;
    word = {8'd0, gathered} | ({24'd0, b} << (8 * byte_pos));
    if (byte_pos + 1 < w) begin
      gathered = word[23:0];
      byte_pos++;
      return;
    end
    case (w)
      1: val = {24'd0, word[7:0]} - 32'd128;
      2: val = {{16{word[15]}}, word[15:0]};
      3: val = {{8{word[23]}}, word[23:0]};
      default: val = word;
    endcase
    fend = (cur_chan + 1 >= nc);
    expected_samples.push_back('{int_to_float(val), cur_chan,
        fend && frames_reg != 0 && frames_done == frames_reg - 1});
    gathered = '0;
    byte_pos = '0;
    if (fend) begin
      cur_chan = '0;
      frames_done++;
    end else begin
      cur_chan++;
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BYTES_PER_SAMPLE: width_reg = val[2:0];
      REG_CHANNEL_COUNT:    chans_reg = val[3:0];
      default:              frames_reg = val;
    endcase
  endtask

  task automatic set_format(int bps, int nch, logic [31:0] nfr);
    write_reg(REG_BYTES_PER_SAMPLE, bps);
    write_reg(REG_CHANNEL_COUNT, nch);
    write_reg(REG_FRAME_COUNT, nfr);
  endtask

  task automatic test_directed();
    set_format(1, 1, 2);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
    set_format(2, 2, 0);
    send_byte(8'h00); send_byte(8'h80); send_byte(8'hFF); send_byte(8'h7F);
    set_format(4, 8, 1);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'h81); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
    set_format(3, 0, 32'hFFFF_FFFF);
    send_byte(8'h55); send_byte(8'hAA); send_byte(8'h80);
    set_format(7, 15, 3);
    send_byte(8'h03); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
    set_format(0, 3, 1);
    send_byte(8'h12);
  endtask

  task automatic test_random(int n);
    int bps, nch, gap;
    for (int seg = 0; seg < 10; seg++) begin
      bps = $urandom_range(0, 7);
      nch = $urandom_range(0, 15);
      set_format(bps, nch, $urandom_range(0, 12));
      for (int i = 0; i < n / 10; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 6);
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        send_byte(8'($urandom_range(0, 255)));
      end
      if (seg == 4) drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    width_reg = 3'd2; chans_reg = 4'd2; frames_reg = '0;
    gathered = '0; byte_pos = '0; cur_chan = '0; frames_done = '0;
    @(posedge clk);
    test_directed();
    test_random(850);
    stall_en = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk) begin
    sample_exp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected sample %h", out_tdata);
      end else begin
        e = expected_samples.pop_front();
        if (out_tdata != {5'd0, e.chan, e.fbits} || out_tlast != e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp %h ch %0d last %0b, got %h ch %0d last %0b",
                e.fbits, e.chan, e.last, out_tdata[31:0], out_tdata[34:32], out_tlast);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
